[sv/crf_pkg.sv]
package crf_pkg;

    localparam int COLOR_W     = 24;
    localparam int COORD_W     = 12;
    localparam int CLIP_W      = 9;
    localparam int REG_W       = 9;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;
    localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_BORDER = 2'd1,
        MODE_READ   = 2'd2,
        MODE_UNUSED = 2'd3
    } t_mode;

    typedef enum logic {
        CMD_FILL = 1'b0,
        CMD_READ = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_mode                      mode;
        logic signed [COORD_W-1:0]  x_a;
        logic signed [COORD_W-1:0]  y_a;
        logic signed [COORD_W-1:0]  x_b;
        logic signed [COORD_W-1:0]  y_b;
        logic [COLOR_W-1:0]         fill_color;
    } t_in_item;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic               read_valid;
    } t_out_item;

    typedef struct packed {
        logic [REG_W-1:0] width;
        logic [REG_W-1:0] height;
    } t_frame;

    typedef struct packed {
        logic              skip;
        logic [CLIP_W-1:0] x0;
        logic [CLIP_W-1:0] x1;
        logic [CLIP_W-1:0] y0;
        logic [CLIP_W-1:0] y1;
    } t_box;

    typedef struct packed {
        t_cmd_kind          kind;
        logic               last;
        t_box               box;
        logic [COLOR_W-1:0] color;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic t_box clip_box(
        input logic signed [COORD_W:0] l,
        input logic signed [COORD_W:0] t,
        input logic signed [COORD_W:0] r,
        input logic signed [COORD_W:0] b,
        input t_frame                  f
    );
        logic signed [COORD_W+1:0] wm1;
        logic signed [COORD_W+1:0] hm1;
        logic signed [COORD_W+1:0] el;
        logic signed [COORD_W+1:0] et;
        logic signed [COORD_W+1:0] er;
        logic signed [COORD_W+1:0] eb;
        logic signed [COORD_W+1:0] cl;
        logic signed [COORD_W+1:0] ct;
        logic signed [COORD_W+1:0] cr;
        logic signed [COORD_W+1:0] cb;
        t_box                      box;
        wm1 = $signed({5'b0, f.width}) - 14'sd1;
        hm1 = $signed({5'b0, f.height}) - 14'sd1;
        el  = $signed({l[COORD_W], l});
        et  = $signed({t[COORD_W], t});
        er  = $signed({r[COORD_W], r});
        eb  = $signed({b[COORD_W], b});
        cl  = (el < 14'sd0) ? 14'sd0 : el;
        ct  = (et < 14'sd0) ? 14'sd0 : et;
        cr  = (er > wm1) ? wm1 : er;
        cb  = (eb > hm1) ? hm1 : eb;
        box.skip = (cl > cr) || (ct > cb);
        box.x0   = cl[CLIP_W-1:0];
        box.x1   = cr[CLIP_W-1:0];
        box.y0   = ct[CLIP_W-1:0];
        box.y1   = cb[CLIP_W-1:0];
        return box;
    endfunction

endpackage

[sv/crf_queue.sv]
module crf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  crf_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output crf_pkg::t_cmd o_cmd,
    output crf_pkg::t_queue_status o_status
);
    import crf_pkg::*;

    t_cmd              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QPTR_W:0]   n_count;
    logic              w_push;
    logic              w_pop;

    assign o_status.full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_cmd  = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[sv/crf_front.sv]
module crf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_block,
    input  crf_pkg::t_in_item i_in_item,
    output logic              o_in_stall,
    input  crf_pkg::t_frame   i_frame,
    input  logic              i_queue_full,
    output logic              o_push,
    output crf_pkg::t_cmd     o_cmd
);
    import crf_pkg::*;

    t_in_item                  r_item;
    logic signed [COORD_W-1:0] r_left;
    logic signed [COORD_W-1:0] r_right;
    logic signed [COORD_W-1:0] r_top;
    logic signed [COORD_W-1:0] r_bottom;
    logic                      r_busy;
    logic                      r_phase;
    logic                      n_busy;
    logic                      n_phase;
    logic                      w_accept;
    logic                      w_in_frame;
    logic signed [COORD_W:0]   w_l;
    logic signed [COORD_W:0]   w_t;
    logic signed [COORD_W:0]   w_r;
    logic signed [COORD_W:0]   w_b;

    assign o_in_stall = r_busy || i_block;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = r_busy && !i_queue_full;

    assign w_l = $signed({r_left[COORD_W-1], r_left});
    assign w_t = $signed({r_top[COORD_W-1], r_top});
    assign w_r = $signed({r_right[COORD_W-1], r_right});
    assign w_b = $signed({r_bottom[COORD_W-1], r_bottom});

    assign w_in_frame = !r_item.x_a[COORD_W-1] && !r_item.y_a[COORD_W-1]
        && (r_item.x_a[COORD_W-2:0] < (COORD_W-1)'(i_frame.width))
        && (r_item.y_a[COORD_W-2:0] < (COORD_W-1)'(i_frame.height));

    always_comb begin
        o_cmd.kind  = CMD_FILL;
        o_cmd.last  = 1'b1;
        o_cmd.color = r_item.fill_color;
        o_cmd.box   = clip_box(w_l, w_t, w_r, w_b, i_frame);
        unique case (r_item.mode)
            MODE_PLAIN: begin
            end
            MODE_BORDER: begin
                if (!r_phase) begin
                    o_cmd.last  = 1'b0;
                    o_cmd.color = COLOR_BLACK;
                    o_cmd.box   = clip_box(w_l - 13'sd1, w_t - 13'sd1,
                                           w_r + 13'sd1, w_b + 13'sd1, i_frame);
                end
            end
            MODE_READ: begin
                o_cmd.kind     = CMD_READ;
                o_cmd.box.skip = !w_in_frame;
                o_cmd.box.x0   = r_item.x_a[CLIP_W-1:0];
                o_cmd.box.y0   = r_item.y_a[CLIP_W-1:0];
            end
            default: begin
                o_cmd.kind     = CMD_READ;
                o_cmd.box.skip = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        if (w_accept) begin
            n_busy  = 1'b1;
            n_phase = 1'b0;
        end else if (o_push) begin
            if (r_item.mode == MODE_BORDER && !r_phase) begin
                n_phase = 1'b1;
            end else begin
                n_busy  = 1'b0;
                n_phase = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item   <= i_in_item;
            r_left   <= (i_in_item.x_a < i_in_item.x_b) ? i_in_item.x_a : i_in_item.x_b;
            r_right  <= (i_in_item.x_a < i_in_item.x_b) ? i_in_item.x_b : i_in_item.x_a;
            r_top    <= (i_in_item.y_a < i_in_item.y_b) ? i_in_item.y_a : i_in_item.y_b;
            r_bottom <= (i_in_item.y_a < i_in_item.y_b) ? i_in_item.y_b : i_in_item.y_a;
        end
    end

endmodule

[sv/crf_back.sv]
module crf_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  crf_pkg::t_cmd      i_cmd,
    input  crf_pkg::t_queue_status i_queue,
    output logic               o_pop,
    output logic               o_clearing,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output crf_pkg::t_out_item o_out_item
);
    import crf_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_START = 6'b000100,
        S_RUN   = 6'b001000,
        S_READ  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    logic [COLOR_W-1:0] r_fb [DEPTH];
    logic [COLOR_W-1:0] r_rdata;
    t_state             r_state;
    t_state             n_state;
    t_cmd               r_cmd;
    t_cmd               n_cmd;
    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      n_addr;
    logic [AW-1:0]      r_row;
    logic [AW-1:0]      n_row;
    logic [CLIP_W-1:0]  r_x;
    logic [CLIP_W-1:0]  n_x;
    logic [CLIP_W-1:0]  r_y;
    logic [CLIP_W-1:0]  n_y;
    logic               r_out_valid;
    logic               n_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;
    logic [AW-1:0]      w_row_base;
    logic [AW-1:0]      w_start_addr;
    logic [AW-1:0]      w_next_row;
    logic               w_we;
    logic [COLOR_W-1:0] w_wdata;
    logic               w_hit;

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_pop       = (r_state == S_IDLE) && !i_queue.empty;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_row_base   = AW'(r_cmd.box.y0) * AW'(MAX_WIDTH);
    assign w_start_addr = w_row_base + AW'(r_cmd.box.x0);
    assign w_next_row   = r_row + AW'(MAX_WIDTH);
    assign w_we         = (r_state == S_CLEAR) || (r_state == S_RUN);
    assign w_wdata      = (r_state == S_CLEAR) ? COLOR_WHITE : r_cmd.color;
    assign w_hit        = (r_cmd.kind == CMD_READ) && !r_cmd.box.skip;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_row       = r_row;
        n_x         = r_x;
        n_y         = r_y;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_CLEAR: begin
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (!i_queue.empty) begin
                    n_cmd   = i_cmd;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_addr = w_start_addr;
                n_row  = w_row_base;
                n_x    = r_cmd.box.x0;
                n_y    = r_cmd.box.y0;
                if (r_cmd.box.skip) begin
                    n_state = S_DONE;
                end else if (r_cmd.kind == CMD_FILL) begin
                    n_state = S_RUN;
                end else begin
                    n_state = S_READ;
                end
            end
            S_RUN: begin
                if (r_x == r_cmd.box.x1) begin
                    if (r_y == r_cmd.box.y1) begin
                        n_state = S_DONE;
                    end else begin
                        n_y    = r_y + 1'b1;
                        n_x    = r_cmd.box.x0;
                        n_row  = w_next_row;
                        n_addr = w_next_row + AW'(r_cmd.box.x0);
                    end
                end else begin
                    n_x    = r_x + 1'b1;
                    n_addr = r_addr + 1'b1;
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_cmd.last) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.pixel_color = w_hit ? r_rdata : '0;
                    n_out.read_valid  = w_hit;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_row <= n_row;
        r_x   <= n_x;
        r_y   <= n_y;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_fb[r_addr] <= w_wdata;
        end
        r_rdata <= r_fb[r_addr];
    end

endmodule

[sv/clipped_rectangle_fill.sv]
// Rectangle fill engine over an internal MAX_WIDTH x MAX_HEIGHT RGB framebuffer.
// Input channel (i_in_valid / o_in_stall / i_in_item): one transaction carries a
// mode, two corners and a color. Output channel (o_out_valid / i_out_stall /
// o_out_item): exactly one transaction per input, in input order; pixel_color
// and read_valid are nonzero only for a read that lands inside the frame.
// APB port: frame_width at address 0, frame_height at address 4; write only
// while the engine is idle. Sizes above the framebuffer act as its maximum.
// After reset the framebuffer is swept to white, one pixel per cycle, over all
// MAX_WIDTH*MAX_HEIGHT pixels (65536 by default); o_in_stall stays high then.
// Structure: a front stage orders and clips the corners and pushes commands into a
// four-entry queue; the back end writes one pixel per cycle through a single
// memory port. A bordered fill first paints the grown rectangle black, then
// the fill itself. The front holds one transaction until all of its commands
// are in the queue, and takes no new one before then.
// While i_out_stall is high the result holds in the output register; the front
// keeps accepting until the queue fills, then o_in_stall rises.
module clipped_rectangle_fill #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  crf_pkg::t_in_item                    i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output crf_pkg::t_out_item                   o_out_item,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [crf_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [crf_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [crf_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import crf_pkg::*;

    logic [REG_W-1:0] r_frame_width;
    logic [REG_W-1:0] r_frame_height;
    t_frame           w_frame;
    logic             w_wr;
    logic             w_push;
    t_cmd             w_front_cmd;
    t_cmd             w_head_cmd;
    logic             w_pop;
    t_queue_status    w_queue;
    logic             w_clearing;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 9'd256;
            r_frame_height <= 9'd256;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[REG_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    assign w_frame.width  = (r_frame_width > MAX_WIDTH) ? REG_W'(MAX_WIDTH) : r_frame_width;
    assign w_frame.height = (r_frame_height > MAX_HEIGHT) ? REG_W'(MAX_HEIGHT)
                                                          : r_frame_height;

    crf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_block      (w_clearing),
        .i_in_item    (i_in_item),
        .o_in_stall   (o_in_stall),
        .i_frame      (w_frame),
        .i_queue_full (w_queue.full),
        .o_push       (w_push),
        .o_cmd        (w_front_cmd)
    );

    crf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_front_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_head_cmd),
        .o_status (w_queue)
    );

    crf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_head_cmd),
        .i_queue     (w_queue),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
